// File: rtl/lru_cache_with_backing_list_defines.svh
// ----------------------------------------------------------------------------
// LRU cache with backing list - assertion macros
// Shared property forms for the checker.
// ----------------------------------------------------------------------------
`ifndef LRU_CACHE_WITH_BACKING_LIST_DEFINES_SVH
`define LRU_CACHE_WITH_BACKING_LIST_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define LCBL_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcbl assertion failed");

// next-cycle implication, sampled on clk, off during reset
`define LCBL_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcbl assertion failed");

`endif

// File: rtl/lcbl_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache with backing list - package
// Shared constants, cell control word and controller state type.
// ----------------------------------------------------------------------------
package lcbl_pkg;

  localparam int DEF_CACHE_DEPTH   = 16;
  localparam int DEF_BACKING_DEPTH = 64;
  localparam int DEF_KEY_WIDTH     = 32;

  localparam int PORT_KEY_W = 32;
  localparam int CNT_W      = 32;
  localparam int CAP_W      = 5;

  localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

  typedef struct packed {
    logic capture;
    logic apply;
    logic hit;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_UPDATE = 2'b10
  } state_t;

endpackage

// File: rtl/lcbl_cache_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache with backing list - cache cell
// One recency slot: compares its key and takes its younger neighbour's key.
// ----------------------------------------------------------------------------
module lcbl_cache_cell import lcbl_pkg::*; #(
  parameter int IDX     = 0,
  parameter int KEY_W   = DEF_KEY_WIDTH,
  parameter int FILL_W  = 5
) (
  input  logic              clk,
  input  cell_ctl_t         ctl,
  input  logic [KEY_W-1:0]  in_key,
  input  logic [KEY_W-1:0]  prev_key,
  input  logic [FILL_W-1:0] fill,
  input  logic [FILL_W-1:0] upto,
  input  logic              seen_in,
  output logic [KEY_W-1:0]  key,
  output logic              seen_out
);

  logic match;
  logic shift;

  assign seen_out = seen_in | match;
  assign shift    = ctl.hit ? !seen_in : (FILL_W'(IDX) <= upto);

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (FILL_W'(IDX) < fill) && (key == in_key);
    end
    if (ctl.apply && shift) begin
      key <= prev_key;
    end
  end

endmodule

// File: rtl/lcbl_backing_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache with backing list - backing cell
// One backing slot: compares, closes the gap on removal, takes an append.
// ----------------------------------------------------------------------------
module lcbl_backing_cell import lcbl_pkg::*; #(
  parameter int IDX     = 0,
  parameter int KEY_W   = DEF_KEY_WIDTH,
  parameter int BFILL_W = 7
) (
  input  logic               clk,
  input  cell_ctl_t          ctl,
  input  logic [KEY_W-1:0]   in_key,
  input  logic [KEY_W-1:0]   next_key,
  input  logic [KEY_W-1:0]   ev_key,
  input  logic [BFILL_W-1:0] bfill,
  input  logic               append,
  input  logic [BFILL_W-1:0] append_at,
  input  logic               seen_in,
  output logic [KEY_W-1:0]   key,
  output logic               seen_out
);

  logic match;

  assign seen_out = seen_in | match;

  always_ff @(posedge clk) begin
    if (ctl.capture) begin
      match <= (BFILL_W'(IDX) < bfill) && (key == in_key);
    end
    if (ctl.apply && !ctl.hit) begin
      if (append && (BFILL_W'(IDX) == append_at)) begin
        key <= ev_key;
      end else if (seen_out) begin
        key <= next_key;
      end
    end
  end

endmodule

// File: rtl/lru_cache_with_backing_list.sv
`timescale 1ns / 1ps
// Each access takes two steps, and no new access is accepted until both are done:
// a compare across both cell rows, then an update in which the cells shift or load
// at once and the result word is registered, held off while a result is unread.
// Reset (synchronous, rst high): fills, counters and result valid clear,
// capacity returns to 16; cell keys are not cleared.
// ----------------------------------------------------------------------------
// LRU cache with backing list - top level
// Recency row and backing row of cells under a two-state controller.
// ----------------------------------------------------------------------------
module lru_cache_with_backing_list import lcbl_pkg::*; #(
  parameter int CACHE_DEPTH   = DEF_CACHE_DEPTH,
  parameter int BACKING_DEPTH = DEF_BACKING_DEPTH,
  parameter int KEY_WIDTH     = DEF_KEY_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_wen,
  input  logic [CAP_W-1:0]      cfg_wdata,
  input  logic                  access_valid,
  output logic                  access_ready,
  input  logic [PORT_KEY_W-1:0] access_key,
  output logic                  result_valid,
  input  logic                  result_ready,
  output logic                  hit,
  output logic                  from_backing,
  output logic                  evicted_valid,
  output logic [PORT_KEY_W-1:0] evicted_key,
  output logic                  overflow,
  output logic [CNT_W-1:0]      hit_count,
  output logic [CNT_W-1:0]      miss_count
);

  localparam int FILL_W  = $clog2(CACHE_DEPTH + 1);
  localparam int BFILL_W = $clog2(BACKING_DEPTH + 1);
  localparam int CMP_W   = (FILL_W > CAP_W) ? FILL_W : CAP_W;

  state_t               state;
  logic [CAP_W-1:0]     capacity;
  logic [FILL_W-1:0]    fill;
  logic [BFILL_W-1:0]   bfill;
  logic [CNT_W-1:0]     hits_seen;
  logic [CNT_W-1:0]     misses_seen;
  logic [KEY_WIDTH-1:0] key_reg;
  logic [KEY_WIDTH-1:0] in_key;

  logic [KEY_WIDTH-1:0] cache_key [CACHE_DEPTH];
  logic                 cache_seen [CACHE_DEPTH+1];
  logic [KEY_WIDTH-1:0] back_key [BACKING_DEPTH];
  logic                 back_seen [BACKING_DEPTH+1];

  cell_ctl_t            ctl;
  logic                 accept;
  logic                 apply;
  logic                 is_hit;
  logic                 found;
  logic                 evict;
  logic                 append;
  logic [CMP_W-1:0]     eff_cap;
  logic [FILL_W-1:0]    upto;
  logic [FILL_W-1:0]    fill_next;
  logic [BFILL_W-1:0]   bfill_rm;
  logic [BFILL_W-1:0]   bfill_next;
  logic [KEY_WIDTH-1:0] ev_key;
  logic [CNT_W-1:0]     hits_next;
  logic [CNT_W-1:0]     misses_next;

  assign in_key       = KEY_WIDTH'(access_key);
  assign access_ready = (state == ST_IDLE);
  assign accept       = access_valid && access_ready;
  assign apply        = (state == ST_UPDATE) && (!result_valid || result_ready);
  assign is_hit       = cache_seen[CACHE_DEPTH];

  assign ctl.capture = accept;
  assign ctl.apply   = apply;
  assign ctl.hit     = is_hit;

  assign cache_seen[0] = 1'b0;
  assign back_seen[0]  = 1'b0;

  always_comb begin
    if (capacity == '0) begin
      eff_cap = CMP_W'(1);
    end else if (CMP_W'(capacity) > CMP_W'(CACHE_DEPTH)) begin
      eff_cap = CMP_W'(CACHE_DEPTH);
    end else begin
      eff_cap = CMP_W'(capacity);
    end
  end

  always_comb begin
    ev_key = '0;
    for (int i = 0; i < CACHE_DEPTH; i++) begin
      if (fill == FILL_W'(i + 1)) begin
        ev_key = ev_key | cache_key[i];
      end
    end
  end

  always_comb begin
    found      = !is_hit && back_seen[BACKING_DEPTH];
    evict      = !is_hit && (fill != '0) && (CMP_W'(fill) >= eff_cap);
    upto       = evict ? fill - FILL_W'(1) : fill;
    fill_next  = (!is_hit && !evict) ? fill + FILL_W'(1) : fill;
    bfill_rm   = found ? bfill - BFILL_W'(1) : bfill;
    append     = evict && (bfill_rm < BFILL_W'(BACKING_DEPTH));
    bfill_next = append ? bfill_rm + BFILL_W'(1) : bfill_rm;
    hits_next   = hits_seen;
    misses_next = misses_seen;
    if (is_hit) begin
      if (hits_seen != '1) hits_next = hits_seen + CNT_W'(1);
    end else begin
      if (misses_seen != '1) misses_next = misses_seen + CNT_W'(1);
    end
  end

  for (genvar i = 0; i < CACHE_DEPTH; i++) begin : g_cache
    lcbl_cache_cell #(
      .IDX    (i),
      .KEY_W  (KEY_WIDTH),
      .FILL_W (FILL_W)
    ) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .in_key   (in_key),
      .prev_key ((i == 0) ? key_reg : cache_key[(i == 0) ? 0 : i - 1]),
      .fill     (fill),
      .upto     (upto),
      .seen_in  (cache_seen[i]),
      .key      (cache_key[i]),
      .seen_out (cache_seen[i+1])
    );
  end

  for (genvar j = 0; j < BACKING_DEPTH; j++) begin : g_back
    lcbl_backing_cell #(
      .IDX     (j),
      .KEY_W   (KEY_WIDTH),
      .BFILL_W (BFILL_W)
    ) u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .in_key    (in_key),
      .next_key  (back_key[(j + 1 < BACKING_DEPTH) ? j + 1 : j]),
      .ev_key    (ev_key),
      .bfill     (bfill),
      .append    (append),
      .append_at (bfill_rm),
      .seen_in   (back_seen[j]),
      .key       (back_key[j]),
      .seen_out  (back_seen[j+1])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_IDLE;
      capacity     <= CAP_RESET;
      fill         <= '0;
      bfill        <= '0;
      hits_seen    <= '0;
      misses_seen  <= '0;
      result_valid <= 1'b0;
    end else begin
      if (cfg_wen) begin
        capacity <= cfg_wdata;
      end
      if (apply) begin
        result_valid <= 1'b1;
      end else if (result_valid && result_ready) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) state <= ST_UPDATE;
        end
        ST_UPDATE: begin
          if (apply) begin
            state        <= ST_IDLE;
            fill         <= fill_next;
            bfill        <= bfill_next;
            hits_seen    <= hits_next;
            misses_seen  <= misses_next;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key_reg <= in_key;
    end
    if (apply) begin
      hit           <= is_hit;
      from_backing  <= found;
      evicted_valid <= evict;
      evicted_key   <= evict ? PORT_KEY_W'(ev_key) : '0;
      overflow      <= evict && !append;
      hit_count     <= hits_next;
      miss_count    <= misses_next;
    end
  end

endmodule

// File: rtl/lcbl_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache with backing list - port checker
// Watches the top-level ports and is bound to every instance of the top.
// ----------------------------------------------------------------------------
`include "lru_cache_with_backing_list_defines.svh"

module lcbl_checker import lcbl_pkg::*; (
  input logic                  clk,
  input logic                  rst,
  input logic                  cfg_wen,
  input logic [CAP_W-1:0]      cfg_wdata,
  input logic                  access_valid,
  input logic                  access_ready,
  input logic [PORT_KEY_W-1:0] access_key,
  input logic                  result_valid,
  input logic                  result_ready,
  input logic                  hit,
  input logic                  from_backing,
  input logic                  evicted_valid,
  input logic [PORT_KEY_W-1:0] evicted_key,
  input logic                  overflow,
  input logic [CNT_W-1:0]      hit_count,
  input logic [CNT_W-1:0]      miss_count
);

  `LCBL_ASSERT_NOW(a_hit_quiet, result_valid && hit, !from_backing && !evicted_valid && !overflow)
  `LCBL_ASSERT_NOW(a_no_evict, result_valid && !evicted_valid, (evicted_key == '0) && !overflow)
  `LCBL_ASSERT_NOW(a_count_live, result_valid, hit ? (hit_count != '0) : (miss_count != '0))
  `LCBL_ASSERT_NEXT(a_one_at_a_time, access_valid && access_ready, !access_ready)
  `LCBL_ASSERT_NEXT(a_result_hold, result_valid && !result_ready, result_valid && $stable(hit_count))

endmodule

bind lru_cache_with_backing_list lcbl_checker u_lcbl_checker (.*);

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// LRU cache with backing list - testbench
// Feeds key accesses through the valid/ready port and rewrites the capacity
// register between phases. Each result word is checked against a local model
// of the recency list, the backing list and the counters. The phases cover
// fixed extremes, random traffic over a shared key pool under three idling
// patterns, and a run of fresh keys at the smallest capacity that fills the
// backing list until it overflows.
// ----------------------------------------------------------------------------
module testbench;
  import lcbl_pkg::*;

  localparam int CACHE_SLOTS  = DEF_CACHE_DEPTH;
  localparam int BACKING_SLOTS = DEF_BACKING_DEPTH;
  localparam int POOL_SIZE    = 48;

  typedef struct packed {
    logic              hit;
    logic              from_backing;
    logic              evicted_valid;
    logic [PORT_KEY_W-1:0] evicted_key;
    logic              overflow;
    logic [CNT_W-1:0]  hit_count;
    logic [CNT_W-1:0]  miss_count;
  } lookup_result_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wen;
  logic [CAP_W-1:0]      cfg_wdata;
  logic                  access_valid;
  logic                  access_ready;
  logic [PORT_KEY_W-1:0] access_key;
  logic                  result_valid;
  logic                  result_ready;
  logic                  hit;
  logic                  from_backing;
  logic                  evicted_valid;
  logic [PORT_KEY_W-1:0] evicted_key;
  logic                  overflow;
  logic [CNT_W-1:0]      hit_count;
  logic [CNT_W-1:0]      miss_count;

  logic [PORT_KEY_W-1:0] mru_keys [CACHE_SLOTS];
  logic [PORT_KEY_W-1:0] victim_keys [BACKING_SLOTS];
  int                    mru_fill;
  int                    victim_fill;
  logic [CNT_W-1:0]      hits_total;
  logic [CNT_W-1:0]      misses_total;
  logic [CAP_W-1:0]      cache_capacity;

  lookup_result_t        pending_lookups [$];
  logic [PORT_KEY_W-1:0] key_pool [POOL_SIZE];
  int                    errors;
  int                    send_idle_pct;
  int                    recv_idle_pct;

  lru_cache_with_backing_list u_dut (
    .clk           (clk),
    .rst           (rst),
    .cfg_wen       (cfg_wen),
    .cfg_wdata     (cfg_wdata),
    .access_valid  (access_valid),
    .access_ready  (access_ready),
    .access_key    (access_key),
    .result_valid  (result_valid),
    .result_ready  (result_ready),
    .hit           (hit),
    .from_backing  (from_backing),
    .evicted_valid (evicted_valid),
    .evicted_key   (evicted_key),
    .overflow      (overflow),
    .hit_count     (hit_count),
    .miss_count    (miss_count)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("FAIL");
    $finish;
  end

  function automatic lookup_result_t predict_access(logic [PORT_KEY_W-1:0] key);
    lookup_result_t r;
    int pos;
    int fill;
    int bfill;
    int cap;
    int i;
    int j;
    r     = '0;
    pos   = -1;
    fill  = mru_fill;
    bfill = victim_fill;
    cap   = (cache_capacity == 0) ? 1 :
            (cache_capacity > CACHE_SLOTS) ? CACHE_SLOTS : int'(cache_capacity);
    for (i = 0; i < fill; i++)
      if (pos < 0 && mru_keys[i] == key) pos = i;
    if (pos >= 0) begin
      r.hit = 1'b1;
      if (hits_total != '1) hits_total++;
      for (i = pos; i > 0; i--) mru_keys[i] = mru_keys[i-1];
      mru_keys[0] = key;
    end else begin
      if (misses_total != '1) misses_total++;
      for (i = 0; i < bfill; i++) begin
        if (victim_keys[i] == key) begin
          for (j = i; j + 1 < bfill; j++) victim_keys[j] = victim_keys[j+1];
          bfill--;
          r.from_backing = 1'b1;
          break;
        end
      end
      if (fill > 0 && fill >= cap) begin
        r.evicted_valid = 1'b1;
        r.evicted_key   = mru_keys[fill-1];
        fill--;
        if (bfill < BACKING_SLOTS) begin
          victim_keys[bfill] = r.evicted_key;
          bfill++;
        end else begin
          r.overflow = 1'b1;
        end
      end
      for (i = fill; i > 0; i--)
        if (i < CACHE_SLOTS) mru_keys[i] = mru_keys[i-1];
      mru_keys[0] = key;
      if (fill < CACHE_SLOTS) fill++;
    end
    mru_fill     = fill;
    victim_fill  = bfill;
    r.hit_count  = hits_total;
    r.miss_count = misses_total;
    return r;
  endfunction

  task automatic report_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s expected %h got %h", $realtime, name, want, got);
    end
  endtask

  always @(posedge clk) begin : result_monitor
    lookup_result_t want;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (pending_lookups.size() == 0) begin
          errors++;
          $display("%0t: result word with nothing expected, expected none got %h",
                   $realtime, evicted_key);
        end else begin
          want = pending_lookups.pop_front();
          report_field("hit", want.hit, hit);
          report_field("from_backing", want.from_backing, from_backing);
          report_field("evicted_valid", want.evicted_valid, evicted_valid);
          report_field("evicted_key", want.evicted_key, evicted_key);
          report_field("overflow", want.overflow, overflow);
          report_field("hit_count", want.hit_count, hit_count);
          report_field("miss_count", want.miss_count, miss_count);
        end
      end
      if (cfg_wen) cache_capacity = cfg_wdata;
      if (access_valid && access_ready)
        pending_lookups.push_back(predict_access(access_key));
    end
  end

  initial begin
    result_ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ready = ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic send_access(logic [PORT_KEY_W-1:0] key);
    while ($urandom_range(99) < send_idle_pct) begin
      access_valid = 1'b0;
      @(negedge clk);
    end
    access_valid = 1'b1;
    access_key   = key;
    @(posedge clk);
    while (!access_ready) @(posedge clk);
    @(negedge clk);
    access_valid = 1'b0;
  endtask

  task automatic wait_idle();
    while (pending_lookups.size() != 0) @(posedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_capacity(logic [CAP_W-1:0] value);
    wait_idle();
    cfg_wen   = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_wen   = 1'b0;
  endtask

  function automatic logic [PORT_KEY_W-1:0] pick_key();
    int r;
    r = $urandom_range(99);
    if (r < 75) return key_pool[$urandom_range(POOL_SIZE-1)];
    if (r < 90) return $urandom;
    return $urandom_range(63);
  endfunction

  task automatic test_key_extremes();
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h0000_0000);
    send_access(32'hFFFF_FFFF);
    send_access(32'h1234_5678);
    send_access(32'hA5A5_A5A5);
    send_access(32'h5A5A_5A5A);
    send_access(32'h8000_0000);
    send_access(32'h0000_0001);
  endtask

  // zero capacity acts as one, so each miss evicts from a one-deep list
  task automatic test_capacity_limits();
    write_capacity(5'd0);
    send_access(32'h1111_1111);
    send_access(32'h2222_2222);
    send_access(32'h0000_0000);
    send_access(32'h0000_0000);
    write_capacity(5'd31);
    send_access(32'h3333_3333);
    send_access(32'h4444_4444);
    write_capacity(5'd16);
  endtask

  task automatic test_random_traffic(int sidle, int ridle, int chunks, int per_chunk);
    int c;
    int n;
    logic [CAP_W-1:0] cap;
    send_idle_pct = sidle;
    recv_idle_pct = ridle;
    for (c = 0; c < chunks; c++) begin
      case (c)
        0:       cap = 5'd16;
        1:       cap = 5'd3;
        2:       cap = 5'd31;
        3:       cap = 5'd0;
        4:       cap = 5'd1;
        default: cap = CAP_W'($urandom_range(31));
      endcase
      write_capacity(cap);
      for (n = 0; n < per_chunk; n++) send_access(pick_key());
    end
  endtask

  task automatic test_backing_overflow();
    int i;
    write_capacity(5'd1);
    for (i = 0; i < 72; i++) send_access({8'hC3, 24'(i)});
    for (i = 0; i < 8; i++) send_access({8'hC3, 24'(i)});
    write_capacity(5'd16);
  endtask

  initial begin
    int i;
    rst            = 1'b1;
    cfg_wen        = 1'b0;
    cfg_wdata      = '0;
    access_valid   = 1'b0;
    access_key     = '0;
    errors         = 0;
    send_idle_pct  = 13;
    recv_idle_pct  = 81;
    mru_fill       = 0;
    victim_fill    = 0;
    hits_total     = '0;
    misses_total   = '0;
    cache_capacity = CAP_RESET;
    for (i = 0; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    repeat (5) @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    test_key_extremes();
    test_capacity_limits();
    test_random_traffic(13, 81, 7, 27);
    test_random_traffic(81, 13, 7, 27);
    test_random_traffic(0, 0, 7, 27);
    test_backing_overflow();

    wait_idle();
    repeat (6) @(negedge clk);
    if (errors == 0 && pending_lookups.size() == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/lcbl_pkg.sv
rtl/lcbl_cache_cell.sv
rtl/lcbl_backing_cell.sv
rtl/lru_cache_with_backing_list.sv
rtl/lcbl_checker.sv
tb/sv/testbench.sv
